// ===== sv/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
// Used by the controller, the datapath, the top level and its checker.
package sha256_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        word_last;
  } out_item_t;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam int unsigned Rounds     = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPRESS,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } ctrl_state_e;

  // Byte source (message data or padding) selected by the controller.
  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_e;

  typedef struct packed {
    logic       push;
    byte_sel_e  bsel;
    logic       add_len;
    logic       start;
    logic       round;
    logic [5:0] round_idx;
    logic       fold;
    logic       reinit;
    logic       out_load;
    logic [2:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } dp_stat_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== sv/sha256_dp.sv =====
// Datapath of the SHA-256 stream hasher: block buffer, schedule, round unit,
// chaining words, length counter and output register. Needs sha256_pkg.
module sha256_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha256_pkg::dp_cmd_t   cmd_i,
  input  logic [7:0]            data_byte_i,
  output sha256_pkg::dp_stat_t  stat_o,
  output logic [31:0]           out_word_o
);
  import sha256_pkg::*;

  logic [31:0] blk_q [16];
  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [2:0]  len_idx_q;
  logic [31:0] out_q;

  logic [7:0]  push_byte;
  logic [31:0] w_cur, s0, s1, t1, t2, e, a, w_new;

  always_comb begin
    case (cmd_i.bsel)
      BSEL_DATA: push_byte = data_byte_i;
      BSEL_MARK: push_byte = 8'h80;
      BSEL_ZERO: push_byte = 8'h00;
      BSEL_LEN:  push_byte = bits_q[8'(7 - len_idx_q) * 8 +: 8];
      default:   push_byte = 8'h00;
    endcase
  end

  // Rolling schedule: w_q[0] is always the word for this round.
  assign s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_new = s1 + w_q[9] + s0 + w_q[0];
  assign w_cur = w_q[0];
  assign e     = v_q[4];
  assign a     = v_q[0];
  assign t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
            + ((e & v_q[5]) ^ (~e & v_q[6])) + RoundK[cmd_i.round_idx] + w_cur;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
            + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      bits_q    <= '0;
      len_idx_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
    end else begin
      if (cmd_i.push) begin
        fill_q <= fill_q + 6'd1;
        if (cmd_i.bsel == BSEL_LEN) len_idx_q <= len_idx_q + 3'd1;
      end
      if (cmd_i.add_len) bits_q <= bits_q + 64'd8;
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.reinit) begin
        for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
        bits_q    <= '0;
        len_idx_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      blk_q[fill_q[5:2]][8'(3 - fill_q[1:0]) * 8 +: 8] <= push_byte;
    end
    if (cmd_i.start) begin
      for (int i = 0; i < 15; i++) w_q[i] <= blk_q[i];
      // The last byte of the block arrives together with the start command.
      w_q[15] <= {blk_q[15][31:8], push_byte};
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (cmd_i.out_load) out_q <= h_q[cmd_i.out_idx];
  end

  assign stat_o.fill = fill_q;
  assign out_word_o  = out_q;

endmodule

// ===== sv/sha256_ctrl.sv =====
// Controller of the SHA-256 stream hasher: sequences appends, compression,
// padding and digest output. Needs sha256_pkg.
module sha256_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  sha256_pkg::in_item_t  in_item_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output logic                  out_last_o,
  input  logic                  out_stall_i,
  output sha256_pkg::dp_cmd_t   cmd_o,
  input  sha256_pkg::dp_stat_t  stat_i
);
  import sha256_pkg::*;

  ctrl_state_e state_q, state_d;
  ctrl_state_e ret_q, ret_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        fold_q, fold_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        ovalid_q, ovalid_d;
  logic        olast_q, olast_d;
  logic        in_acc;
  logic        full_next;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign full_next = (stat_i.fill == 6'(BlockBytes - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    rnd_d   = rnd_q;
    fold_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item_i.func == FUNC_APPEND) begin
            if (full_next) begin
              state_d = ST_COMPRESS; ret_d = ST_IDLE; rnd_d = '0;
            end
          end else if (full_next) begin
            state_d = ST_COMPRESS; ret_d = ST_PAD; rnd_d = '0;
          end else if (stat_i.fill == 6'(LenPos - 1)) begin
            state_d = ST_LEN;
          end else begin
            state_d = ST_PAD;
          end
        end
      end
      ST_COMPRESS: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(Rounds - 1)) begin
          fold_d  = 1'b1;
          state_d = ret_q;
        end
      end
      ST_PAD: begin
        if (!fold_q) begin
          if (full_next) begin
            state_d = ST_COMPRESS; ret_d = ST_PAD; rnd_d = '0;
          end else if (stat_i.fill == 6'(LenPos - 1)) begin
            state_d = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (full_next) begin
          state_d = ST_COMPRESS; ret_d = ST_EMIT; rnd_d = '0;
        end
      end
      ST_EMIT: begin
        if (!fold_q && olast_q && ovalid_q && !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd_o           = '0;
    cmd_o.bsel      = BSEL_DATA;
    cmd_o.round_idx = rnd_q;
    cmd_o.out_idx   = oidx_q;
    oidx_d          = oidx_q;
    ovalid_d        = ovalid_q;
    olast_d         = olast_q;
    in_stall_o      = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.push = 1'b1;
          if (in_item_i.func == FUNC_APPEND) begin
            cmd_o.add_len = 1'b1;
          end else begin
            cmd_o.bsel = BSEL_MARK;
          end
          cmd_o.start = full_next;
        end
      end
      ST_COMPRESS: cmd_o.round = 1'b1;
      ST_PAD: begin
        if (!fold_q) begin
          cmd_o.push  = 1'b1;
          cmd_o.bsel  = BSEL_ZERO;
          cmd_o.start = full_next;
        end
      end
      ST_LEN: begin
        cmd_o.push  = 1'b1;
        cmd_o.bsel  = BSEL_LEN;
        cmd_o.start = full_next;
      end
      ST_EMIT: begin
        if (!fold_q) begin
          if (!ovalid_q || !out_stall_i) begin
            if (ovalid_q && olast_q) begin
              ovalid_d     = 1'b0;
              olast_d      = 1'b0;
              oidx_d       = '0;
              cmd_o.reinit = 1'b1;
            end else begin
              cmd_o.out_load = 1'b1;
              ovalid_d       = 1'b1;
              olast_d        = (oidx_q == 3'd7);
              oidx_d         = oidx_q + 3'd1;
            end
          end
        end
      end
      default: ;
    endcase
    cmd_o.fold = fold_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      rnd_q    <= '0;
      fold_q   <= 1'b0;
      oidx_q   <= '0;
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      rnd_q    <= rnd_d;
      fold_q   <= fold_d;
      oidx_q   <= oidx_d;
      ovalid_q <= ovalid_d;
      olast_q  <= olast_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_last_o  = olast_q;

endmodule

// ===== sv/sha256_stream_hasher_core.sv =====
// Top level of the SHA-256 stream hasher: joins controller and datapath.
// Needs sha256_pkg, sha256_ctrl and sha256_dp.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | in_item_i (func, data_byte)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (digest_word, word_last)
//
// An append is accepted in the idle state; the 64th byte of a block starts the
// rounds, one per cycle in a single shared round unit; the fold overlaps the
// next request.
// A finish pads one byte a cycle, pausing while a fold is done, compresses
// one or two blocks and then shows eight digest words, one per cycle when not stalled.
// Reset returns the chaining words to their initial values at once.
// Requests are stalled while the block compresses, pads or emits.
module sha256_stream_hasher_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sha256_pkg::in_item_t   in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output sha256_pkg::out_item_t  out_item_o
);
  import sha256_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        last;
  logic [31:0] word;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_item_i, .in_stall_o,
    .out_valid_o, .out_last_o(last), .out_stall_i,
    .cmd_o(cmd), .stat_i(stat)
  );

  sha256_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .data_byte_i(in_item_i.data_byte),
    .stat_o(stat), .out_word_o(word)
  );

  assign out_item_o.digest_word = word;
  assign out_item_o.word_last   = last;

endmodule

// ===== sv/sha256_checker.sv =====
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Needs sha256_pkg.
module sha256_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input sha256_pkg::out_item_t out_item_o
);
  import sha256_pkg::*;

  // A result held back by stall keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // No request is taken while digest words are shown.
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted during output");

  // After the last word is taken the next cycle shows no result.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_item_o.word_last |=> !out_valid_o)
    else $error("result after last word");

  // A taken non-final word is followed by a further word.
  a_words_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.word_last |=> out_valid_o)
    else $error("digest burst broken");

endmodule

bind sha256_stream_hasher_core sha256_checker u_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .out_item_o
);

// ===== tb/sv/tb_top.sv =====
// Testbench for the SHA-256 stream hasher: drives byte and finish requests,
// predicts each digest with its own SHA-256 and checks every digest word.
// Depends on sha256_pkg and sha256_stream_hasher_core.
`timescale 1ns / 100ps

class digest_board;
  logic [31:0] chain_q [8];
  logic [7:0]  blk_q [64];
  int unsigned fill_q;
  logic [63:0] nbits_q;
  sha256_pkg::out_item_t want_q [$];
  int unsigned mismatches;

  function void restart();
    chain_q = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    fill_q = 0;
    nbits_q = '0;
  endfunction

  function new();
    restart();
    mismatches = 0;
  endfunction

  function logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    logic [31:0] kk [64];
    kk = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    for (int i = 0; i < 16; i++)
      w[i] = {blk_q[4*i], blk_q[4*i+1], blk_q[4*i+2], blk_q[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = chain_q;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kk[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] += v[i];
  endfunction

  function void add_byte(logic [7:0] b);
    blk_q[fill_q] = b;
    fill_q = (fill_q + 1) % 64;
    if (fill_q == 0) compress();
  endfunction

  // Notes one accepted request and queues any digest words it causes.
  function void note_request(sha256_pkg::in_item_t it);
    sha256_pkg::out_item_t o;
    if (it.func == sha256_pkg::FUNC_APPEND) begin
      nbits_q += 64'd8;
      add_byte(it.data_byte);
    end else begin
      add_byte(8'h80);
      while (fill_q != sha256_pkg::LenPos) add_byte(8'h00);
      for (int i = 7; i >= 0; i--) add_byte(nbits_q[8*i +: 8]);
      for (int i = 0; i < 8; i++) begin
        o.digest_word = chain_q[i];
        o.word_last = (i == 7);
        want_q.push_back(o);
      end
      restart();
    end
  endfunction

  function void check_word(sha256_pkg::out_item_t got);
    sha256_pkg::out_item_t exp_w;
    if (want_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected digest word %h last %b",
                                     got.digest_word, got.word_last);
      return;
    end
    exp_w = want_q.pop_front();
    if (got.digest_word !== exp_w.digest_word || got.word_last !== exp_w.word_last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %h last %b, got %h last %b", exp_w.digest_word,
                 exp_w.word_last, got.digest_word, got.word_last);
    end
  endfunction
endclass

module tb_top;
  import sha256_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  digest_board board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  longint unsigned cycles = 0;
  int unsigned left_in_msg = 0;

  sha256_stream_hasher_core DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 64'd1500000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver side: checks accepted words and stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_word(out_item_o);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Valid stays high after acceptance until the next request, an idle cycle
  // or a drain drops it, so it is assigned only once per clock edge.
  task automatic send(input logic f, input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i.func <= f;
    in_item_i.data_byte <= b;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request('{func: f, data_byte: b});
  endtask

  task automatic send_msg(input int unsigned len);
    for (int i = 0; i < len; i++) send(FUNC_APPEND, 8'($urandom));
    send(FUNC_FINISH, 8'($urandom));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.want_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase_pct [4][2];
    int unsigned r;
    phase_pct = '{'{0, 0}, '{55, 0}, '{0, 55}, '{30, 30}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, finish with data set, byte extremes,
    // messages that leave exactly 55 and 56 bytes in a block, and one that fills a whole block.
    send(FUNC_FINISH, 8'h00);
    send(FUNC_FINISH, 8'hff);
    send(FUNC_APPEND, 8'h00);
    send(FUNC_APPEND, 8'hff);
    send(FUNC_APPEND, 8'h55);
    send(FUNC_APPEND, 8'haa);
    send(FUNC_FINISH, 8'h00);
    drain();
    send_msg(55);
    send_msg(56);
    send_msg(64);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      for (int n = 0; n < 72; n++) begin
        // Mostly short messages; now and then a stray finish or a long one.
        r = $urandom_range(99);
        if (left_in_msg == 0)
          left_in_msg = (r < 5) ? $urandom_range(120, 200) : $urandom_range(0, 20);
        if (left_in_msg == 1 || r < 3) begin
          send(FUNC_FINISH, 8'($urandom));
          left_in_msg = 0;
        end else begin
          send(FUNC_APPEND, 8'($urandom));
          left_in_msg--;
        end
      end
      send(FUNC_FINISH, 8'($urandom));
      left_in_msg = 0;
      drain();
    end

    recv_stall_pct = 0;
    drain();
    repeat (200) @(posedge clk_i);
    if (board.mismatches == 0 && board.want_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
